/* rtl/kmps_pkg.sv */
// kmps_pkg: field widths, command codes and the control/status bundles
// shared by the kth-marked-position select controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package kmps_pkg;

   localparam int POS_W  = 11;
   localparam int VAL_W  = 32;
   localparam int RANK_W = 11;
   localparam int CNT_W  = 32;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [POS_W-1:0] CFG_RESET = 11'd1024;

   typedef struct packed {
      logic clear_step;
      logic load_write;
      logic mark_start;
      logic mark_step;
      logic query_start;
      logic query_step;
      logic out_load;
   } kmps_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pos_ok;
      logic mark_last;
      logic query_last;
      logic out_free;
   } kmps_status_type;

endpackage

/* rtl/kmps_ctrl.sv */
// kmps_ctrl: sequencer for the clearing pass, mark tree update and query descent.
// Depends on kmps_pkg; drives the command bundle of kmps_datapath.
`timescale 1ns / 1ps

module kmps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_command,
   output logic                    req_ready,
   input  kmps_pkg::kmps_status_type status,
   output kmps_pkg::kmps_cmd_type    cmd
);
   import kmps_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MARK  = 3'd2;
   localparam logic [2:0] S_QUERY = 3'd3;
   localparam logic [2:0] S_QDONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_LOAD: begin
                     cmd.load_write = status.pos_ok;
                  end
                  CMD_MARK: begin
                     if (status.pos_ok) begin
                        cmd.mark_start = 1'b1;
                        state_in       = S_MARK;
                     end
                  end
                  CMD_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = S_QUERY;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (status.mark_last) begin
               state_in = S_IDLE;
            end
         end
         S_QUERY: begin
            cmd.query_step = 1'b1;
            if (status.query_last) begin
               state_in = S_QDONE;
            end
         end
         S_QDONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/kmps_datapath.sv */
// kmps_datapath: mark count tree memory, value memory, descent registers and
// the result word register. Depends on kmps_pkg; commanded by kmps_ctrl.
`timescale 1ns / 1ps

module kmps_datapath #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kmps_pkg::kmps_cmd_type            cmd,
   output kmps_pkg::kmps_status_type         status,
   input  logic [kmps_pkg::POS_W-1:0]        req_position,
   input  logic signed [kmps_pkg::VAL_W-1:0] req_value,
   input  logic [kmps_pkg::RANK_W-1:0]       req_rank,
   input  logic                              csr_write_enable,
   input  logic [kmps_pkg::POS_W-1:0]        csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kmps_pkg::POS_W-1:0]        rsp_found_position,
   output logic signed [kmps_pkg::VAL_W-1:0] rsp_found_value,
   output logic                              rsp_not_found
);
   import kmps_pkg::*;

   localparam int NW    = $clog2(TABLE_SIZE + 1);
   localparam int AW    = $clog2(TABLE_SIZE);
   localparam int PW    = NW + 1;
   localparam int XW    = (PW > POS_W) ? PW : POS_W;
   localparam int TOP_I = 1 << (NW - 1);
   localparam logic [NW-1:0] TOP_STEP = NW'(TOP_I);
   localparam logic [AW-1:0] TOP_IDX  = AW'(TOP_I - 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
   localparam logic [XW-1:0] SIZE_X   = XW'(TABLE_SIZE);

   logic [CNT_W-1:0]        tree_mem [TABLE_SIZE];
   logic signed [VAL_W-1:0] val_mem  [TABLE_SIZE];

   logic [POS_W-1:0]        n_cfg_ff;
   logic [AW-1:0]           clr_ff;
   logic [PW-1:0]           node_ff;
   logic [NW-1:0]           at_ff;
   logic [NW-1:0]           step_ff;
   logic [RANK_W-1:0]       rem_ff;
   logic                    rank_nz_ff;
   logic                    found_ff;
   logic [POS_W-1:0]        fpos_ff;
   logic [CNT_W-1:0]        tree_q_ff;
   logic signed [VAL_W-1:0] val_q_ff;
   logic                    rsp_valid_ff;
   logic [POS_W-1:0]        rsp_pos_ff;
   logic signed [VAL_W-1:0] rsp_val_ff;
   logic                    rsp_nf_ff;

   logic [XW-1:0]    cfg_x;
   logic [XW-1:0]    n_x;
   logic [XW-1:0]    pos_x;
   logic [PW-1:0]    req_node;
   logic [PW-1:0]    req_m1;
   logic [PW-1:0]    node_m1;
   logic [PW-1:0]    low_bit;
   logic [PW-1:0]    node_next;
   logic [PW-1:0]    next_m1;
   logic [PW-1:0]    nx;
   logic             take;
   logic [NW-1:0]    at_next;
   logic [RANK_W-1:0] rem_next;
   logic [NW-1:0]    step_next;
   logic [PW-1:0]    qaddr;
   logic             found_next;
   logic [PW-1:0]    at_p1;
   logic             tree_rd_en;
   logic [AW-1:0]    tree_rd_idx;
   logic             tree_we;
   logic [AW-1:0]    tree_wr_idx;
   logic [CNT_W-1:0] tree_wr_data;

   assign cfg_x = XW'(n_cfg_ff);
   assign n_x   = (cfg_x > SIZE_X) ? SIZE_X : cfg_x;
   assign pos_x = XW'(req_position);

   assign req_node = PW'(req_position);
   assign req_m1   = req_node - PW'(1);
   assign node_m1  = node_ff - PW'(1);

   assign low_bit   = node_ff & (~node_ff + PW'(1));
   assign node_next = node_ff + low_bit;
   assign next_m1   = node_next - PW'(1);

   assign nx        = PW'(at_ff) + PW'(step_ff);
   assign take      = (XW'(nx) <= n_x) && (tree_q_ff < CNT_W'(rem_ff));
   assign at_next   = take ? nx[NW-1:0] : at_ff;
   assign rem_next  = take ? (rem_ff - tree_q_ff[RANK_W-1:0]) : rem_ff;
   assign step_next = step_ff >> 1;
   assign qaddr     = PW'(at_next) + PW'(step_next) - PW'(1);
   assign found_next = rank_nz_ff && (XW'(at_next) < n_x);
   assign at_p1     = PW'(at_next) + PW'(1);

   assign status.clear_last = (clr_ff == LAST_IDX);
   assign status.pos_ok     = (pos_x != '0) && (pos_x <= SIZE_X);
   assign status.mark_last  = (XW'(node_next) > SIZE_X);
   assign status.query_last = (step_next == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      tree_rd_en = cmd.mark_start | cmd.mark_step | cmd.query_start | cmd.query_step;
      if (cmd.mark_start) begin
         tree_rd_idx = req_m1[AW-1:0];
      end else if (cmd.mark_step) begin
         tree_rd_idx = next_m1[AW-1:0];
      end else if (cmd.query_start) begin
         tree_rd_idx = TOP_IDX;
      end else begin
         tree_rd_idx = qaddr[AW-1:0];
      end
      tree_we      = cmd.clear_step | cmd.mark_step;
      tree_wr_idx  = cmd.clear_step ? clr_ff : node_m1[AW-1:0];
      tree_wr_data = cmd.clear_step ? '0 : (tree_q_ff + CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_wr_idx] <= tree_wr_data;
      end
      if (tree_rd_en) begin
         tree_q_ff <= tree_mem[tree_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         val_mem[req_m1[AW-1:0]] <= req_value;
      end
      if (cmd.query_step && status.query_last) begin
         val_q_ff <= val_mem[at_next[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_cfg_ff     <= CFG_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            n_cfg_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_start) begin
         node_ff <= req_node;
      end else if (cmd.mark_step) begin
         node_ff <= node_next;
      end
      if (cmd.query_start) begin
         at_ff      <= '0;
         step_ff    <= TOP_STEP;
         rem_ff     <= req_rank;
         rank_nz_ff <= (req_rank != '0);
      end else if (cmd.query_step) begin
         at_ff   <= at_next;
         step_ff <= step_next;
         rem_ff  <= rem_next;
         if (status.query_last) begin
            found_ff <= found_next;
            fpos_ff  <= POS_W'(at_p1);
         end
      end
      if (cmd.out_load) begin
         rsp_pos_ff <= found_ff ? fpos_ff : POS_W'(1);
         rsp_val_ff <= found_ff ? val_q_ff : '0;
         rsp_nf_ff  <= !found_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_found_value    = rsp_val_ff;
   assign rsp_not_found      = rsp_nf_ff;

endmodule

/* rtl/kth_marked_position_select_unit.sv */
// kth_marked_position_select_unit: top level joining kmps_ctrl and kmps_datapath.
// Depends on kmps_pkg, kmps_ctrl and kmps_datapath.
//
//   channel | direction | handshake         | word
//   req     | in        | req_valid/ready   | command, position, value, rank
//   rsp     | out       | rsp_valid/ready   | found_position, found_value, not_found
//   csr     | in        | csr_write_enable  | positions_in_use
//
// Load: a single value memory write from the idle state. Mark: walks the nodes on the tree update path.
// Query: descends the count tree, one tree memory read per descent level.
// After reset a clearing pass over all TABLE_SIZE entries zeroes the count tree; req_ready is low.
// A finished query waits in its final state only while the result register is still full.
`timescale 1ns / 1ps

module kth_marked_position_select_unit #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [kmps_pkg::CMD_W-1:0]        req_command,
   input  logic [kmps_pkg::POS_W-1:0]        req_position,
   input  logic signed [kmps_pkg::VAL_W-1:0] req_value,
   input  logic [kmps_pkg::RANK_W-1:0]       req_rank,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kmps_pkg::POS_W-1:0]        rsp_found_position,
   output logic signed [kmps_pkg::VAL_W-1:0] rsp_found_value,
   output logic                              rsp_not_found,
   input  logic                              csr_write_enable,
   input  logic [kmps_pkg::POS_W-1:0]        csr_write_data
);
   import kmps_pkg::*;

   kmps_cmd_type    cmd;
   kmps_status_type status;

   kmps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   kmps_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_rank           (req_rank),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_position (rsp_found_position),
      .rsp_found_value    (rsp_found_value),
      .rsp_not_found      (rsp_not_found)
   );

endmodule

/* verif/kth_marked_position_select_unit_tb.sv */
// kth_marked_position_select_unit_tb: self-checking bench for the k-th marked position select.
// Loads, marks and queries on random handshakes are checked against a local binary indexed tree.
// Depends on kmps_pkg and kth_marked_position_select_unit.
`timescale 1ns / 1ps

module kth_marked_position_select_unit_tb;
   import kmps_pkg::*;

   localparam int TABLE_SIZE = 1024;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_FIELD = 2047;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic                    miss;
   } select_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command;
   logic [POS_W-1:0]         req_position;
   logic signed [VAL_W-1:0]  req_value;
   logic [RANK_W-1:0]        req_rank;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [POS_W-1:0]         rsp_found_position;
   logic signed [VAL_W-1:0]  rsp_found_value;
   logic                     rsp_not_found;
   logic                     csr_write_enable;
   logic [POS_W-1:0]         csr_write_data;

   logic [CNT_W-1:0]         mark_tree [1:TABLE_SIZE];
   logic signed [VAL_W-1:0]  stored_value [1:TABLE_SIZE];
   bit                       value_loaded [1:TABLE_SIZE];
   logic [POS_W-1:0]         search_limit;
   select_result_type        expected_selects [$];

   int unsigned              fail_count;
   int unsigned              timeout_count;
   int unsigned              hold_requests;
   bit                       req_eager;
   bit                       rsp_eager;

   kth_marked_position_select_unit #(
      .TABLE_SIZE(TABLE_SIZE)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_rank           (req_rank),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_position (rsp_found_position),
      .rsp_found_value    (rsp_found_value),
      .rsp_not_found      (rsp_not_found),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit position_ok(input logic [POS_W-1:0] pos);
      return pos >= 1 && pos <= TABLE_SIZE;
   endfunction

   function automatic int unsigned active_limit();
      return (search_limit > POS_W'(TABLE_SIZE)) ? TABLE_SIZE : 32'(search_limit);
   endfunction

   function automatic void tree_add_mark(input int unsigned pos);
      int unsigned p;
      p = pos;
      while (p <= TABLE_SIZE) begin
         mark_tree[p] += 1;
         p += p & (0 - p);
      end
   endfunction

   function automatic int unsigned marks_up_to(input int unsigned n);
      int unsigned p;
      int unsigned sum;
      p = n;
      sum = 0;
      while (p > 0) begin
         sum += mark_tree[p];
         p -= p & (0 - p);
      end
      return sum;
   endfunction

   function automatic select_result_type select_kth_mark(input logic [RANK_W-1:0] rank);
      select_result_type res;
      int unsigned       n;
      int unsigned       at;
      int unsigned       step;
      int unsigned       nx;
      logic [CNT_W-1:0]  remaining;
      n = active_limit();
      at = 0;
      remaining = CNT_W'(rank);
      step = 1;
      while (step <= TABLE_SIZE / 2) step <<= 1;
      while (step != 0) begin
         nx = at + step;
         if (nx <= n && mark_tree[nx] < remaining) begin
            at = nx;
            remaining -= mark_tree[nx];
         end
         step >>= 1;
      end
      if (rank != 0 && at + 1 <= n) begin
         res.position = POS_W'(at + 1);
         res.value    = stored_value[at + 1];
         res.miss     = 1'b0;
      end else begin
         res.position = POS_W'(1);
         res.value    = '0;
         res.miss     = 1'b1;
      end
      return res;
   endfunction

   function automatic void predict_word(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos,
                                        input logic signed [VAL_W-1:0] word_value,
                                        input logic [RANK_W-1:0] rank);
      case (cmd)
         CMD_LOAD: begin
            if (position_ok(pos)) begin
               stored_value[pos] = word_value;
               value_loaded[pos] = 1'b1;
            end
         end
         CMD_MARK: begin
            if (position_ok(pos)) tree_add_mark(32'(pos));
         end
         CMD_QUERY: begin
            expected_selects.push_front(select_kth_mark(rank));
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] word_value,
                            input logic [RANK_W-1:0] rank);
      int unsigned gap;
      gap = req_eager ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= word_value;
      req_rank     <= rank;
      do @(posedge clock); while (!req_ready);
      predict_word(cmd, pos, word_value, rank);
   endtask

   task automatic wait_until_drained();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_selects.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_selects.size() != 0) begin
         timeout_count++;
         $display("%0t: timeout, %0d results outstanding", $time, expected_selects.size());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_positions_in_use(input logic [POS_W-1:0] limit);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      search_limit = limit;
   endtask

   task automatic load_position(input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] word_value);
      send_word(CMD_LOAD, pos, word_value, RANK_W'($urandom_range(0, MAX_FIELD)));
   endtask

   // load first so that a query never lands on an unwritten entry
   task automatic mark_position(input logic [POS_W-1:0] pos);
      if (position_ok(pos) && !value_loaded[pos]) load_position(pos, $urandom());
      send_word(CMD_MARK, pos, $urandom(), RANK_W'($urandom_range(0, MAX_FIELD)));
   endtask

   task automatic query_rank(input logic [RANK_W-1:0] rank);
      send_word(CMD_QUERY, POS_W'($urandom_range(0, MAX_FIELD)), $urandom(), rank);
   endtask

   function automatic logic [POS_W-1:0] pick_position();
      int unsigned roll;
      int unsigned n;
      roll = $urandom_range(0, 99);
      n = active_limit();
      if (roll < 2) return '0;
      if (roll < 6) return POS_W'($urandom_range(TABLE_SIZE + 1, MAX_FIELD));
      if (roll < 60 && n != 0) return POS_W'($urandom_range(1, n));
      return POS_W'($urandom_range(1, TABLE_SIZE));
   endfunction

   task automatic random_query();
      int unsigned roll;
      int unsigned total;
      int unsigned rank;
      roll = $urandom_range(0, 99);
      total = marks_up_to(active_limit());
      if (roll < 75 && total != 0) begin
         rank = $urandom_range(1, (total > MAX_FIELD) ? MAX_FIELD : total);
      end else if (roll < 85) begin
         rank = total + $urandom_range(1, 3);
         if (rank > MAX_FIELD) rank = MAX_FIELD;
      end else if (roll < 90) begin
         rank = 0;
      end else begin
         rank = $urandom_range(0, MAX_FIELD);
      end
      query_rank(RANK_W'(rank));
   endtask

   task automatic run_random_traffic(input int unsigned word_count);
      int unsigned roll;
      for (int unsigned i = 0; i < word_count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            load_position(pick_position(), $urandom());
         end else if (roll < 60) begin
            mark_position(pick_position());
         end else if (roll < 95) begin
            random_query();
         end else begin
            send_word(CMD_UNUSED, POS_W'($urandom_range(0, MAX_FIELD)), $urandom(),
                      RANK_W'($urandom_range(0, MAX_FIELD)));
         end
      end
   endtask

   task automatic test_reset_state();
      query_rank('0);
      query_rank(RANK_W'(1));
      query_rank(RANK_W'(MAX_FIELD));
   endtask

   task automatic test_field_extremes();
      load_position(POS_W'(1), 32'sh7fffffff);
      load_position(POS_W'(TABLE_SIZE), 32'sh80000000);
      load_position('0, -32'sd1);
      load_position(POS_W'(MAX_FIELD), '0);
      mark_position(POS_W'(1));
      mark_position(POS_W'(TABLE_SIZE));
      mark_position(POS_W'(TABLE_SIZE));
      mark_position('0);
      mark_position(POS_W'(TABLE_SIZE + 1));
      mark_position(POS_W'(MAX_FIELD));
      send_word(CMD_UNUSED, POS_W'(1), -32'sd1, RANK_W'(1));
      send_word(CMD_QUERY, POS_W'(MAX_FIELD), -32'sd1, RANK_W'(1));
      send_word(CMD_QUERY, '0, '0, RANK_W'(2));
      query_rank(RANK_W'(3));
      query_rank(RANK_W'(4));
      query_rank('0);
      query_rank(RANK_W'(MAX_FIELD));
   endtask

   task automatic test_config_settings();
      write_positions_in_use('0);
      query_rank(RANK_W'(1));
      write_positions_in_use(POS_W'(1));
      query_rank(RANK_W'(1));
      query_rank(RANK_W'(2));
      write_positions_in_use(POS_W'(MAX_FIELD));
      query_rank(RANK_W'(3));
      write_positions_in_use(POS_W'(TABLE_SIZE + 1));
      query_rank(RANK_W'(2));
      write_positions_in_use(POS_W'(TABLE_SIZE - 1));
      query_rank(RANK_W'(2));
   endtask

   task automatic test_full_window_random();
      write_positions_in_use(POS_W'(TABLE_SIZE));
      run_random_traffic(200);
   endtask

   task automatic test_back_to_back();
      req_eager = 1'b1;
      rsp_eager = 1'b1;
      run_random_traffic(150);
      req_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   task automatic test_output_backpressure();
      hold_requests++;
      req_eager = 1'b1;
      repeat (40) random_query();
      req_eager = 1'b0;
      wait_until_drained();
   endtask

   task automatic test_sender_pause();
      run_random_traffic(50);
      wait_until_drained();
      run_random_traffic(50);
   endtask

   task automatic test_narrow_windows();
      write_positions_in_use(POS_W'(64));
      run_random_traffic(150);
      write_positions_in_use(POS_W'($urandom_range(2, TABLE_SIZE - 1)));
      run_random_traffic(150);
      write_positions_in_use(POS_W'(1));
      run_random_traffic(60);
   endtask

   task automatic test_saturated_window();
      write_positions_in_use(POS_W'(MAX_FIELD));
      run_random_traffic(150);
   endtask

   initial begin : rsp_ready_driver
      int unsigned stall;
      int unsigned holds_done;
      holds_done = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            stall = HOLD_CYCLES;
            holds_done = hold_requests;
         end else begin
            stall = rsp_eager ? 0 : $urandom_range(0, 9);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_results
      select_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_selects.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual pos %0d value %0d nf %0b",
                     $time, rsp_found_position, rsp_found_value, rsp_not_found);
         end else begin
            want = expected_selects.pop_back();
            if (rsp_found_position !== want.position) begin
               fail_count++;
               $display("%0t: found_position mismatch: expected %0d, actual %0d",
                        $time, want.position, rsp_found_position);
            end
            if (rsp_found_value !== want.value) begin
               fail_count++;
               $display("%0t: found_value mismatch: expected %0d, actual %0d",
                        $time, want.value, rsp_found_value);
            end
            if (rsp_not_found !== want.miss) begin
               fail_count++;
               $display("%0t: not_found mismatch: expected %0b, actual %0b",
                        $time, want.miss, rsp_not_found);
            end
         end
      end
   end

   initial begin
      timeout_count    = 0;
      hold_requests    = 0;
      req_eager        = 1'b0;
      rsp_eager        = 1'b0;
      search_limit     = CFG_RESET;
      for (int i = 1; i <= TABLE_SIZE; i++) begin
         mark_tree[i]    = '0;
         stored_value[i] = '0;
         value_loaded[i] = 1'b0;
      end
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_LOAD;
      req_position     <= '0;
      req_value        <= '0;
      req_rank         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_config_settings();
      test_full_window_random();
      test_back_to_back();
      test_output_backpressure();
      test_sender_pause();
      test_narrow_windows();
      test_saturated_window();

      wait_until_drained();
      if (fail_count == 0 && timeout_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
